[rtl/mge_pkg.sv]
package mge_pkg;

    // input word kinds, carried on s_tuser
    typedef enum logic [1:0] {
        ACT_SET_PEN = 2'd0,
        ACT_BEGIN   = 2'd1,
        ACT_BYTE    = 2'd2
    } act_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_FG_COLOR       = 3'd0,
        CFG_BG_COLOR       = 3'd1,
        CFG_BG_TRANSPARENT = 3'd2,
        CFG_LINE_PITCH     = 3'd3,
        CFG_GLYPH_HEIGHT   = 3'd4
    } cfg_index_t;

    // commands handed from front to back
    typedef enum logic [1:0] {
        CMD_ABANDON = 2'd0,
        CMD_BEGIN   = 2'd1,
        CMD_BYTE    = 2'd2
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_BYTE = 1'b1
    } bk_state_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [12:0] origin_x;
        logic [10:0] pen_y;
        logic [6:0]  width;
        logic [7:0]  bits;
    } cmd_t;

    typedef struct packed {
        logic [15:0] fg_color;
        logic [15:0] bg_color;
        logic        bg_transparent;
        logic [12:0] line_pitch;
        logic [6:0]  glyph_height;
    } cfg_t;

    localparam int          Q_DEPTH   = 4;
    localparam logic [12:0] PEN_X_MAX = 13'h1FFF;

    localparam logic [15:0] FG_RESET     = 16'hFFFF;
    localparam logic [15:0] BG_RESET     = 16'h0000;
    localparam logic [12:0] PITCH_RESET  = 13'd640;
    localparam logic [6:0]  HEIGHT_RESET = 7'd16;

endpackage

[rtl/mge_queue.sv]
module mge_queue #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mge_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output mge_pkg::cmd_t head_cmd
);
    import mge_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/mge_front.sv]
module mge_front #(
    parameter int MAX_GLYPH_WIDTH = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [1:0]    s_tuser,
    input  logic [39:0]   s_tdata,
    input  logic          q_full,
    output logic          q_push,
    output mge_pkg::cmd_t q_cmd
);
    import mge_pkg::*;

    localparam logic [7:0] W_MAX = 8'(MAX_GLYPH_WIDTH);

    logic [12:0] pen_x_reg, pen_x_next;
    logic [10:0] pen_y_reg, pen_y_next;
    logic        take;
    logic [6:0]  w_in, w_sat;
    logic [13:0] x_sum;

    always_comb begin
        s_tready   = ~q_full;
        take       = s_tvalid & ~q_full;
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        q_push     = 1'b0;

        w_in  = s_tdata[28:22];
        w_sat = ({1'b0, w_in} > W_MAX) ? 7'(MAX_GLYPH_WIDTH) : w_in;
        x_sum = {1'b0, pen_x_reg} + 14'(w_sat);

        q_cmd.kind     = CMD_BYTE;
        q_cmd.origin_x = pen_x_reg;
        q_cmd.pen_y    = pen_y_reg;
        q_cmd.width    = w_sat;
        q_cmd.bits     = s_tdata[36:29];

        case (act_t'(s_tuser))
            ACT_SET_PEN: begin
                q_cmd.kind = CMD_ABANDON;
                q_push     = take;
                if (take) begin
                    pen_x_next = {2'b00, s_tdata[10:0]};
                    pen_y_next = s_tdata[21:11];
                end
            end
            ACT_BEGIN: begin
                q_cmd.kind = CMD_BEGIN;
                q_push     = take;
                if (take) begin
                    pen_x_next = x_sum[13] ? PEN_X_MAX : x_sum[12:0];
                end
            end
            ACT_BYTE: begin
                q_cmd.kind = CMD_BYTE;
                q_push     = take;
            end
            default: begin
                q_push = 1'b0;  // unused code, dropped
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
        end else begin
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
        end
    end

endmodule

[rtl/mge_back.sv]
module mge_back #(
    parameter int MAX_GLYPH_HEIGHT = 64,
    parameter int MAX_PITCH        = 4096
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  mge_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  mge_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,
    output logic          m_tlast
);
    import mge_pkg::*;

    localparam logic [7:0]  H_MAX = 8'(MAX_GLYPH_HEIGHT);
    localparam logic [13:0] P_MAX = 14'(MAX_PITCH);

    bk_state_t   state_reg, state_next;
    logic [12:0] origin_reg, origin_next;
    logic [10:0] base_y_reg, base_y_next;
    logic [6:0]  width_reg, width_next;
    logic [6:0]  row_reg, row_next;
    logic [6:0]  col_reg, col_next;
    logic        active_reg, active_next;
    logic [7:0]  bits_reg, bits_next;
    logic [2:0]  bitcnt_reg, bitcnt_next;
    logic        hold_valid_reg, hold_valid_next;
    logic        hold_last_reg, hold_last_next;
    logic [23:0] hold_off_reg, hold_off_next;
    logic [15:0] hold_color_reg, hold_color_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        m_tlast_reg, m_tlast_next;
    logic [39:0] m_tdata_reg, m_tdata_next;

    logic [7:0]  h8, col_inc, row_inc;
    logic [13:0] pitch;
    logic        in_step, row_out, wrap, emit, last_step;
    logic        move, out_free, step_go, can_pop;
    logic [11:0] y_line;
    logic [25:0] prod;
    logic [23:0] offset;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        state_next      = state_reg;
        origin_next     = origin_reg;
        base_y_next     = base_y_reg;
        width_next      = width_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        active_next     = active_reg;
        bits_next       = bits_reg;
        bitcnt_next     = bitcnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_last_next  = hold_last_reg;
        hold_off_next   = hold_off_reg;
        hold_color_next = hold_color_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tlast_next    = m_tlast_reg;
        m_tdata_next    = m_tdata_reg;

        h8    = ({1'b0, cfg.glyph_height} > H_MAX) ? H_MAX : {1'b0, cfg.glyph_height};
        pitch = ({1'b0, cfg.line_pitch} > P_MAX) ? P_MAX : {1'b0, cfg.line_pitch};

        // one glyph bit per cycle while no write waits on a stalled output
        in_step   = (state_reg == BK_BYTE);
        row_out   = ({1'b0, row_reg} >= h8);
        col_inc   = {1'b0, col_reg} + 8'd1;
        row_inc   = {1'b0, row_reg} + 8'd1;
        wrap      = (col_inc >= {1'b0, width_reg});
        emit      = in_step & ~row_out & (bits_reg[7] | ~cfg.bg_transparent);
        last_step = row_out | (wrap & (row_inc >= h8)) | (&bitcnt_reg);

        y_line = {1'b0, base_y_reg} + {5'b0, row_reg};
        prod   = y_line * pitch;
        offset = prod[23:0] + {11'b0, origin_reg} + {17'b0, col_reg};

        // hold keeps the newest write until we know whether it ends the byte
        move     = hold_valid_reg & (hold_last_reg | (in_step & (emit | last_step)));
        out_free = ~m_tvalid_reg | m_tready;
        step_go  = in_step & (~move | out_free);

        if (move && out_free) begin
            m_tvalid_next   = 1'b1;
            m_tdata_next    = {hold_color_reg, hold_off_reg};
            m_tlast_next    = hold_last_reg | (in_step & last_step & ~emit);
            hold_valid_next = 1'b0;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (step_go) begin
            if (emit) begin
                hold_valid_next = 1'b1;
                hold_last_next  = last_step;
                hold_off_next   = offset;
                hold_color_next = bits_reg[7] ? cfg.fg_color : cfg.bg_color;
            end
            bits_next   = {bits_reg[6:0], 1'b0};
            bitcnt_next = bitcnt_reg + 3'd1;
            if (row_out) begin
                active_next = 1'b0;
            end else if (wrap) begin
                col_next = '0;
                row_next = row_inc[6:0];
                if (row_inc >= h8) begin
                    active_next = 1'b0;
                end
            end else begin
                col_next = col_inc[6:0];
            end
            if (last_step) begin
                state_next = BK_IDLE;
            end
        end

        // next command may enter on the final bit of the current byte
        can_pop = (state_reg == BK_IDLE) | (step_go & last_step);
        q_pop   = q_valid & can_pop;

        if (q_pop) begin
            case (q_cmd.kind)
                CMD_ABANDON: begin
                    active_next = 1'b0;
                end
                CMD_BEGIN: begin
                    origin_next = q_cmd.origin_x;
                    base_y_next = q_cmd.pen_y;
                    width_next  = q_cmd.width;
                    row_next    = '0;
                    col_next    = '0;
                    active_next = (q_cmd.width != '0) && (h8 != '0);
                end
                CMD_BYTE: begin
                    if (active_next) begin
                        state_next  = BK_BYTE;
                        bits_next   = q_cmd.bits;
                        bitcnt_next = '0;
                    end
                end
                default: begin
                    active_next = active_next;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            origin_reg     <= '0;
            base_y_reg     <= '0;
            width_reg      <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            active_reg     <= 1'b0;
            bitcnt_reg     <= '0;
            hold_valid_reg <= 1'b0;
            hold_last_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            origin_reg     <= origin_next;
            base_y_reg     <= base_y_next;
            width_reg      <= width_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            active_reg     <= active_next;
            bitcnt_reg     <= bitcnt_next;
            hold_valid_reg <= hold_valid_next;
            hold_last_reg  <= hold_last_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg       <= bits_next;
        hold_off_reg   <= hold_off_next;
        hold_color_reg <= hold_color_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
    end

endmodule

[rtl/mono_glyph_color_expander.sv]
// Monochrome glyph color expander.
// s_ channel: one word per command. s_tuser selects it: set pen, begin glyph
// (placed at the pen, pen then moves right by the width, saturating) or one
// bitmap byte, MSB first, bits running on across rows.
// m_ channel: one framebuffer write per word, offset and 16-bit color;
// m_tlast marks the final write caused by a byte. Bytes that write nothing
// produce no words.
// cfg_wr_en/cfg_addr/cfg_wdata: register writes, taken at any edge with
// cfg_wr_en high; the user must write them only while the block is idle;
// the block itself does not enforce this. Path: with the queue empty, an
// accepted byte is popped from the queue, stepped bit by bit into the hold,
// and moved from the hold into the output register when the next bit also
// writes. A write waits in the hold until the next write or the byte ends.
// Throughput: one glyph bit per cycle while no write waits on a stalled
// output, up to the 8 bits of a byte; the single bit-step unit with its
// offset multiplier sets this. The back end takes one pen or glyph command
// per cycle. s_tready only drops when the 4-entry command queue is full.
// Reset (aresetn low, synchronous): registers to defaults, pen at 0,0, no
// glyph active, queue and output emptied.
// Stall: m_tdata/m_tlast hold while m_tvalid is high and m_tready low; the
// back end stops, the queue fills, then s_tready falls.
module mono_glyph_color_expander #(
    parameter int MAX_GLYPH_HEIGHT = 64,
    parameter int MAX_GLYPH_WIDTH  = 64,
    parameter int MAX_PITCH        = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,    // action
    input  logic [39:0] s_tdata,    // pen_x_in[10:0], pen_y_in[21:11],
                                    // glyph_width_in[28:22], bitmap_byte[36:29]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // pixel_offset[23:0], pixel_color[39:24]
    output logic        m_tlast,    // last_of_byte
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import mge_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic q_push, q_full, q_pop, q_valid;
    cmd_t push_cmd, head_cmd;

    // register file
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_addr))
                CFG_FG_COLOR:       cfg_next.fg_color       = cfg_wdata;
                CFG_BG_COLOR:       cfg_next.bg_color       = cfg_wdata;
                CFG_BG_TRANSPARENT: cfg_next.bg_transparent = cfg_wdata[0];
                CFG_LINE_PITCH:     cfg_next.line_pitch     = cfg_wdata[12:0];
                CFG_GLYPH_HEIGHT:   cfg_next.glyph_height   = cfg_wdata[6:0];
                default:            cfg_next = cfg_reg;   // no such register
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fg_color       <= FG_RESET;
            cfg_reg.bg_color       <= BG_RESET;
            cfg_reg.bg_transparent <= 1'b1;
            cfg_reg.line_pitch     <= PITCH_RESET;
            cfg_reg.glyph_height   <= HEIGHT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: pen tracking, command decode
    mge_front #(
        .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    mge_queue #(
        .DEPTH(Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_valid),
        .head_cmd  (head_cmd)
    );

    // back: glyph walk and pixel writes
    mge_back #(
        .MAX_GLYPH_HEIGHT(MAX_GLYPH_HEIGHT),
        .MAX_PITCH       (MAX_PITCH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

[rtl/mge_checker.sv]
module mge_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed under stall");

    // reset empties the output register
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // reset empties the command queue
    a_rst_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind mono_glyph_color_expander mge_checker u_mge_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

[bench/tb_mono_glyph_color_expander.sv]
module tb_mono_glyph_color_expander;
    timeunit 1ns;
    timeprecision 1ps;

    import mge_pkg::*;

    // block limits, also handed to the instance
    localparam int MAX_GLYPH_H  = 64;
    localparam int MAX_GLYPH_W  = 64;
    localparam int MAX_PITCH_PX = 4096;

    localparam logic [1:0] ACT_UNUSED = 2'd3;  // spare action code, must be ignored

    localparam int CYCLE_LIMIT = 300000;  // run watchdog
    localparam int SETTLE      = 64;      // cycles to let empty bytes flush
    localparam int LONG_STALL  = 150;     // receiver hold-off, in cycles
    localparam int MAX_REPORTS = 10;

    // one input word as the driver sees it
    typedef struct packed {
        logic [1:0]  action;
        logic [10:0] pen_x;
        logic [10:0] pen_y;
        logic [6:0]  width;
        logic [7:0]  glyph_bits;
        logic        wait_drain;  // hold this word back until no write is outstanding
    } glyph_word_t;

    // one framebuffer write
    typedef struct packed {
        logic [23:0] offset;
        logic [15:0] color;
        logic        last;
    } pixel_write_t;

    // ---------------------------------------------------------------- DUT ports
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser   = ACT_SET_PEN;
    logic [39:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr  = CFG_FG_COLOR;
    logic [15:0] cfg_wdata = '0;

    mono_glyph_color_expander #(
        .MAX_GLYPH_HEIGHT(MAX_GLYPH_H),
        .MAX_GLYPH_WIDTH (MAX_GLYPH_W),
        .MAX_PITCH       (MAX_PITCH_PX)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    // ---------------------------------------------------------------- bench state
    glyph_word_t  glyph_words[$];     // words waiting to go out
    pixel_write_t pending_writes[$];  // writes the block still owes us

    int send_idle_pct    = 0;
    int ready_stall_pct  = 0;
    int long_stall_reqs  = 0;
    int long_stalls_done = 0;
    int stall_left       = 0;

    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int cycles     = 0;

    // shadow copy of the registers
    logic [15:0] cfg_fg     = FG_RESET;
    logic [15:0] cfg_bg     = BG_RESET;
    logic        cfg_transp = 1'b1;
    logic [12:0] cfg_pitch  = PITCH_RESET;
    logic [6:0]  cfg_height = HEIGHT_RESET;

    // shadow copy of the pen and glyph walker
    logic [12:0] pen_col    = '0;
    logic [10:0] pen_row    = '0;
    logic [12:0] glyph_x0   = '0;
    logic [6:0]  glyph_w    = '0;
    logic [6:0]  cur_row    = '0;
    logic [6:0]  cur_col    = '0;
    logic        glyph_live = 1'b0;

    // ---------------------------------------------------------------- clock, watchdog
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d writes still owed", cycles,
                     pending_writes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor
    // height and pitch are read live and clamped to the block limits
    function automatic int eff_height();
        return (cfg_height > MAX_GLYPH_H) ? MAX_GLYPH_H : int'(cfg_height);
    endfunction

    function automatic int eff_pitch();
        return (cfg_pitch > MAX_PITCH_PX) ? MAX_PITCH_PX : int'(cfg_pitch);
    endfunction

    // apply one accepted word, queue the writes it must produce
    function automatic void paint_word(input glyph_word_t w);
        pixel_write_t outs[8];
        int           n;
        int           b;
        int           h;
        int           nx;
        logic         done;
        logic         set;
        logic [7:0]   shreg;
        logic [6:0]   wd;
        logic [63:0]  off;
        n    = 0;
        done = 1'b0;
        case (w.action)
            ACT_SET_PEN: begin
                // also drops any glyph in progress
                pen_col    = {2'b00, w.pen_x};
                pen_row    = w.pen_y;
                glyph_live = 1'b0;
            end
            ACT_BEGIN: begin
                wd         = (w.width > MAX_GLYPH_W) ? 7'(MAX_GLYPH_W) : w.width;
                glyph_x0   = pen_col;
                glyph_w    = wd;
                cur_row    = '0;
                cur_col    = '0;
                glyph_live = (wd != 0) && (eff_height() != 0);
                nx         = int'(pen_col) + int'(wd);
                pen_col    = (nx > int'(PEN_X_MAX)) ? PEN_X_MAX : 13'(nx);
            end
            ACT_BYTE: begin
                if (glyph_live) begin
                    h     = eff_height();
                    shreg = w.glyph_bits;
                    for (b = 0; b < 8 && !done; b++) begin
                        set   = shreg[7];
                        shreg = shreg << 1;
                        if (cur_row >= h) begin
                            // height dropped under the current row
                            glyph_live = 1'b0;
                            done       = 1'b1;
                        end else begin
                            if (set || !cfg_transp) begin
                                off = (64'(pen_row) + 64'(cur_row)) * 64'(eff_pitch())
                                    + 64'(glyph_x0) + 64'(cur_col);
                                outs[n].offset = off[23:0];
                                outs[n].color  = set ? cfg_fg : cfg_bg;
                                outs[n].last   = 1'b0;
                                n++;
                            end
                            cur_col++;
                            if (cur_col >= glyph_w) begin
                                cur_col = '0;
                                cur_row++;
                                if (cur_row >= h) begin
                                    // rest of the byte is thrown away
                                    glyph_live = 1'b0;
                                    done       = 1'b1;
                                end
                            end
                        end
                    end
                    if (n > 0)
                        outs[n - 1].last = 1'b1;
                    for (b = 0; b < n; b++)
                        pending_writes.push_back(outs[b]);
                end
            end
            default: ;  // spare code: nothing happens
        endcase
    endfunction

    // ---------------------------------------------------------------- driver
    // holds s_tvalid until the word is taken; idles at random between words
    always @(posedge aclk) begin : drive_proc
        glyph_word_t cur;
        logic        offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                paint_word(cur);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                offer = (glyph_words.size() > 0) &&
                        (send_idle_pct == 0 || $urandom_range(99) >= send_idle_pct);
                if (offer && glyph_words[0].wait_drain && pending_writes.size() != 0)
                    offer = 1'b0;
                if (offer) begin
                    cur = glyph_words.pop_front();
                    s_tuser  <= cur.action;
                    s_tdata  <= {3'b000, cur.glyph_bits, cur.width, cur.pen_y, cur.pen_x};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver pacing
    // random stalls per phase, plus one-off long hold-offs on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (long_stall_reqs != long_stalls_done) begin
            long_stalls_done++;
            stall_left = LONG_STALL - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (ready_stall_pct == 0) || ($urandom_range(99) >= ready_stall_pct);
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge aclk) begin : check_proc
        pixel_write_t got;
        pixel_write_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.offset = m_tdata[23:0];
            got.color  = m_tdata[39:24];
            got.last   = m_tlast;
            n_results++;
            if (pending_writes.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("Unexpected write %0d: offset %06h color %04h last %0b",
                             n_results, got.offset, got.color, got.last);
            end else begin
                want = pending_writes.pop_front();
                if (got.offset !== want.offset || got.color !== want.color ||
                    got.last !== want.last) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display({"Mismatch on write %0d: expected offset %06h color %04h ",
                                  "last %0b, got offset %06h color %04h last %0b"},
                                 n_results, want.offset, want.color, want.last,
                                 got.offset, got.color, got.last);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus helpers
    // unused fields carry random values; the block must ignore them
    function automatic glyph_word_t any_word(input logic [1:0] act);
        glyph_word_t w;
        w.action     = act;
        w.pen_x      = 11'($urandom_range(2047));
        w.pen_y      = 11'($urandom_range(2047));
        w.width      = 7'($urandom_range(127));
        w.glyph_bits = 8'($urandom_range(255));
        w.wait_drain = 1'b0;
        return w;
    endfunction

    function automatic glyph_word_t pen_word(input int x, input int y);
        glyph_word_t w;
        w       = any_word(ACT_SET_PEN);
        w.pen_x = 11'(x);
        w.pen_y = 11'(y);
        return w;
    endfunction

    function automatic glyph_word_t begin_word(input int width);
        glyph_word_t w;
        w       = any_word(ACT_BEGIN);
        w.width = 7'(width);
        return w;
    endfunction

    function automatic glyph_word_t byte_word(input int pattern);
        glyph_word_t w;
        w            = any_word(ACT_BYTE);
        w.glyph_bits = 8'(pattern);
        return w;
    endfunction

    // mostly well-formed glyphs (begin + the bytes they need), some cut short or
    // overrun, plus stray words of every kind
    task automatic push_text(input int n_words);
        int made;
        int r;
        int w;
        int ws;
        int nb;
        int i;
        int pat;
        made = 0;
        while (made < n_words) begin
            r = $urandom_range(99);
            if (r < 10) begin
                glyph_words.push_back(any_word(2'($urandom_range(3))));
                made++;
            end else if (r < 20) begin
                glyph_words.push_back(pen_word($urandom_range(2047), $urandom_range(2047)));
                made++;
            end else begin
                r = $urandom_range(99);
                if (r < 70)      w = $urandom_range(1, 12);
                else if (r < 85) w = $urandom_range(13, 64);
                else if (r < 95) w = $urandom_range(65, 127);
                else             w = 0;
                ws = (w > MAX_GLYPH_W) ? MAX_GLYPH_W : w;
                if (ws == 0 || eff_height() == 0)
                    nb = $urandom_range(1);
                else
                    nb = (ws * eff_height() + 7) / 8;
                if (nb > 12)
                    nb = $urandom_range(1, 12);
                r = $urandom_range(99);
                if (r < 15)      nb = nb + $urandom_range(1, 2);
                else if (r < 30) nb = $urandom_range(nb);
                glyph_words.push_back(begin_word(w));
                for (i = 0; i < nb; i++) begin
                    r = $urandom_range(99);
                    if (r < 10)      pat = 8'h00;
                    else if (r < 20) pat = 8'hFF;
                    else             pat = $urandom_range(255);
                    glyph_words.push_back(byte_word(pat));
                end
                made += 1 + nb;
            end
        end
    endtask

    // register write at a clock edge, shadow updated with the same masking
    task automatic set_reg(input cfg_index_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_FG_COLOR:       cfg_fg     = val;
            CFG_BG_COLOR:       cfg_bg     = val;
            CFG_BG_TRANSPARENT: cfg_transp = val[0];
            CFG_LINE_PITCH:     cfg_pitch  = val[12:0];
            CFG_GLYPH_HEIGHT:   cfg_height = val[6:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_pacing(input int send_pct, input int ready_pct);
        @(negedge aclk);
        send_idle_pct   = send_pct;
        ready_stall_pct = ready_pct;
    endtask

    // everything sent, every write back, then a settle wait so empty bytes flush
    task automatic drain_all();
        while (glyph_words.size() != 0 || s_tvalid || pending_writes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_colors(input int fg, input int bg, input int transp);
        set_reg(CFG_FG_COLOR, 16'(fg));
        set_reg(CFG_BG_COLOR, 16'(bg));
        set_reg(CFG_BG_TRANSPARENT, 16'(transp));
    endtask

    task automatic set_geometry(input int pitch, input int height);
        set_reg(CFG_LINE_PITCH, 16'(pitch));
        set_reg(CFG_GLYPH_HEIGHT, 16'(height));
    endtask

    // ---------------------------------------------------------------- test sequence
    initial begin : stim_proc
        glyph_word_t hold_word;
        int          base;
        int          i;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset registers: opaque off, pitch 640, 16 rows
        set_pacing(0, 0);
        glyph_words.push_back(pen_word(0, 0));
        glyph_words.push_back(begin_word(8));
        glyph_words.push_back(byte_word(8'hFF));      // full row of fg
        glyph_words.push_back(byte_word(8'h00));      // transparent: writes nothing
        glyph_words.push_back(byte_word(8'h81));
        glyph_words.push_back(any_word(ACT_UNUSED));  // spare code ignored
        glyph_words.push_back(pen_word(2047, 2047));  // abandons the glyph
        glyph_words.push_back(byte_word(8'hA5));      // no glyph: ignored
        glyph_words.push_back(begin_word(0));         // zero width, pen unchanged
        glyph_words.push_back(byte_word(8'hFF));
        glyph_words.push_back(begin_word(127));       // clamps to max width
        glyph_words.push_back(byte_word(8'h5A));
        glyph_words.push_back(byte_word(8'hFF));
        glyph_words.push_back(begin_word(64));
        glyph_words.push_back(byte_word(8'h01));
        glyph_words.push_back(pen_word(5, 3));
        glyph_words.push_back(begin_word(1));         // one column, bits walk down rows
        glyph_words.push_back(byte_word(8'hFF));
        glyph_words.push_back(byte_word(8'h80));
        glyph_words.push_back(byte_word(8'hFF));      // glyph already done
        drain_all();

        // Directed, opaque with inverted colors, widest pitch, 3 rows
        set_colors(16'h0000, 16'hFFFF, 0);
        set_geometry(MAX_PITCH_PX, 3);
        set_pacing(0, 0);
        glyph_words.push_back(pen_word(2047, 2047));
        glyph_words.push_back(begin_word(5));         // 15 bits: last bit of byte 2 dropped
        glyph_words.push_back(byte_word(8'hFF));
        glyph_words.push_back(byte_word(8'h00));
        glyph_words.push_back(byte_word(8'hAA));
        glyph_words.push_back(begin_word(64));
        glyph_words.push_back(byte_word(8'h0F));
        glyph_words.push_back(pen_word(0, 0));
        glyph_words.push_back(begin_word(8));
        glyph_words.push_back(byte_word(8'hC3));      // row 0 done, glyph stays open
        drain_all();
        // height cut under the open glyph's current row: next byte writes nothing
        set_geometry(MAX_PITCH_PX, 1);
        set_pacing(0, 0);
        glyph_words.push_back(byte_word(8'hFF));
        drain_all();
        // zero height: begin leaves no glyph open
        set_reg(CFG_GLYPH_HEIGHT, 16'd0);
        set_pacing(0, 0);
        glyph_words.push_back(begin_word(8));
        glyph_words.push_back(byte_word(8'hFF));
        drain_all();

        // Random, no idling, oversize pitch and height, long receiver hold-off
        set_colors($urandom_range(16'hFFFF), $urandom_range(16'hFFFF), 0);
        set_geometry(8191, 127);
        set_pacing(0, 0);
        push_text(45);
        base = n_accepted;
        while (n_accepted < base + 15)
            @(negedge aclk);
        long_stall_reqs++;
        drain_all();

        // Random, sender idles; pen walked into saturation first
        set_colors(16'hFFFF, 16'h0000, 1);
        set_geometry(1, 1);
        set_pacing(49, 0);
        glyph_words.push_back(pen_word(2047, $urandom_range(2047)));
        for (i = 0; i < 100; i++)
            glyph_words.push_back(begin_word($urandom_range(64, 127)));
        glyph_words.push_back(begin_word(8));
        glyph_words.push_back(byte_word(8'hFF));
        glyph_words.push_back(byte_word(8'h0F));
        push_text(40);
        drain_all();

        // Random, receiver stalls, zero pitch
        set_colors($urandom_range(16'hFFFF), $urandom_range(16'hFFFF), 0);
        set_geometry(0, 2);
        set_pacing(0, 49);
        push_text(45);
        drain_all();

        // Random, both sides idle; sender waits for a full drain midway
        set_colors($urandom_range(16'hFFFF), $urandom_range(16'hFFFF), $urandom_range(1));
        set_geometry($urandom_range(1, MAX_PITCH_PX), $urandom_range(1, 16));
        set_pacing(34, 34);
        push_text(28);
        hold_word            = pen_word($urandom_range(2047), $urandom_range(2047));
        hold_word.wait_drain = 1'b1;
        glyph_words.push_back(hold_word);
        push_text(28);
        drain_all();

        $display("Covered %0d input words and %0d checked pixel writes across six phases",
                 n_accepted, n_results);
        $display("  (register extremes, live height cut, pen saturation, stalls and pauses)");
        if (n_errors == 0 && pending_writes.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d writes never seen", n_errors, pending_writes.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
